FILE: rtl/core/ptm_pkg.sv
// Package for the page table map/unmap engine: codes, widths, shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptm_pkg;

  localparam int MAX_TABLES_DEF = 16;
  localparam int IDX_W          = 9;    // entries per table = 2**IDX_W
  localparam int VA_W           = 48;
  localparam int PA_W           = 52;
  localparam int PFN_W          = 40;   // physical frame number bits 51..12
  localparam int VPN_W          = 37;   // virtual page number, one extra bit for the end
  localparam int PAGES_W        = 37;
  localparam int LIMIT_W        = 5;
  localparam int ENTRY_W        = 64;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_RANGE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_PRES = 2'd2
  } status_t;

  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_TABLE_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_CLR_ROOT,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_LEAF,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PFN_W-1:0]   pool_pfn;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic [PAGES_W-1:0] pages_done;
    logic [VA_W-1:0]    invalidate_addr;
    logic [LIMIT_W-1:0] tables_used;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/core/ptm_if.sv
// Request and result channel interfaces for the page table engine.
// Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ptm_req_if import ptm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [VA_W-1:0]    virt_addr;
  logic [PA_W-1:0]    phys_addr;
  logic [63:0]        flags;
  logic [VA_W-1:0]    length_bytes;
  modport source (output valid, cmd, virt_addr, phys_addr, flags, length_bytes,
                  input ready);
  modport sink   (input valid, cmd, virt_addr, phys_addr, flags, length_bytes,
                  output ready);
endinterface

interface ptm_rsp_if import ptm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               success;
  logic [1:0]         status;
  logic [PAGES_W-1:0] pages_done;
  logic [VA_W-1:0]    invalidate_addr;
  logic [LIMIT_W-1:0] tables_used;
  modport source (output valid, success, status, pages_done, invalidate_addr,
                  tables_used, input ready);
  modport sink   (input valid, success, status, pages_done, invalidate_addr,
                  tables_used, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ptm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/ptm_walker.sv
// Table walk sequencer: root clear, walk, allocate/clear, leaf write, range loop.
// Depends on ptm_pkg and ptm_ram.
`timescale 1ns / 1ps
`default_nettype none
module ptm_walker import ptm_pkg::*; #(
  parameter int MAX_TABLES = MAX_TABLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        start,
  input  wire logic [1:0]  cmd,
  input  wire logic [VA_W-1:0] virt_addr,
  input  wire logic [PA_W-1:0] phys_addr,
  input  wire logic [63:0] flags,
  input  wire logic [VA_W-1:0] length_bytes,
  output logic             idle,
  output logic             res_valid,
  input  wire logic        res_take,
  output res_t             res
);
  localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int CW    = $clog2(MAX_TABLES + 1);
  localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = MAX_TABLES << IDX_W;

  state_t state, state_next;

  logic [IDX_W-1:0]   clr_cnt;
  logic [1:0]         lvl;
  logic [TW-1:0]      tbl;
  logic [CW-1:0]      alloc;
  logic [1:0]         cmd_r;
  logic [VA_W-1:0]    virt_r;
  logic [VA_W-1:0]    len_r;
  logic [63:0]        flags_r;
  logic [VPN_W-1:0]   vpg;
  logic [VPN_W-1:0]   end_pg;
  logic [PFN_W-1:0]   ppg;
  logic [PAGES_W-1:0] pages;
  logic [VA_W-13:0]   inval_pg;
  logic               ok;
  logic [1:0]         status;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  logic [IDX_W-1:0]  idx;
  logic [PFN_W-1:0]  ent_n;
  logic              hit;
  logic [LW-1:0]     lim;
  logic              full;
  logic [49:0]       end_sum;
  logic [VPN_W:0]    end_raw;
  logic              is_unmap;

  ptm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign is_unmap = (cmd_r == CMD_UNMAP);

  always_comb begin
    case (lvl)
      2'd0:    idx = vpg[35:27];
      2'd1:    idx = vpg[26:18];
      default: idx = vpg[17:9];
    endcase
  end

  // present entry must point into the allocated part of the pool
  assign ent_n = rdata[51:12] - cfg.pool_pfn;
  assign hit   = rdata[0] && (ent_n < PFN_W'(alloc));
  assign lim   = (LW'(cfg.limit) < LW'(MAX_TABLES)) ? LW'(cfg.limit) : LW'(MAX_TABLES);
  assign full  = (LW'(alloc) >= lim);

  assign end_sum = {2'b0, virt_r} + {2'b0, len_r} + 50'd4095;
  assign end_raw = end_sum[49:12];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR_ROOT: if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:     if (start) state_next = (cmd == CMD_NONE) ? S_DONE : S_SETUP;
      S_SETUP: begin
        if (cmd_r == CMD_RANGE && {1'b0, virt_r[47:12]} >=
            ((end_raw > (VPN_W+1)'(1) << 36) ? VPN_W'(1) << 36 : end_raw[VPN_W-1:0]))
          state_next = S_DONE;
        else
          state_next = S_READ;
      end
      S_READ:     state_next = S_CHECK;
      S_CHECK: begin
        if (hit)                state_next = (lvl == 2'd2) ? S_LEAF : S_READ;
        else if (is_unmap || full) state_next = S_DONE;
        else                    state_next = S_CLEAR;
      end
      S_CLEAR:    if (clr_cnt == '1) state_next = (lvl == 2'd2) ? S_LEAF : S_READ;
      S_LEAF:     state_next = S_NEXT;
      S_NEXT:     state_next = (vpg + VPN_W'(1) < end_pg) ? S_READ : S_DONE;
      S_DONE:     if (res_take) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = {tbl, idx};
    unique case (state)
      S_CLR_ROOT: begin
        we    = 1'b1;
        waddr = {TW'(0), clr_cnt};
      end
      S_CHECK: begin
        if (!hit && !is_unmap && !full) begin
          we    = 1'b1;
          waddr = {tbl, idx};
          wdata = {12'b0, cfg.pool_pfn + PFN_W'(alloc), 12'h003};
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = {tbl, clr_cnt};
      end
      S_LEAF: begin
        we    = 1'b1;
        waddr = {tbl, vpg[IDX_W-1:0]};
        wdata = is_unmap ? '0 : ({12'b0, ppg, 12'b0} | flags_r | 64'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR_ROOT;
      clr_cnt <= '0;
      alloc   <= CW'(1);
    end else begin
      state <= state_next;
      unique case (state)
        S_CLR_ROOT: clr_cnt <= clr_cnt + IDX_W'(1);
        S_IDLE: if (start) begin
          cmd_r    <= cmd;
          virt_r   <= virt_addr;
          len_r    <= length_bytes;
          flags_r  <= flags;
          vpg      <= {1'b0, virt_addr[47:12]};
          ppg      <= phys_addr[51:12];
          pages    <= '0;
          inval_pg <= '0;
          ok       <= 1'b0;
          status   <= ST_OK;
        end
        S_SETUP: begin
          ok  <= 1'b1;
          lvl <= 2'd0;
          tbl <= '0;
          if (cmd_r == CMD_RANGE)
            end_pg <= (end_raw > (VPN_W+1)'(1) << 36) ? VPN_W'(1) << 36
                                                      : end_raw[VPN_W-1:0];
          else
            end_pg <= vpg + VPN_W'(1);
        end
        S_CHECK: begin
          if (hit) begin
            tbl <= ent_n[TW-1:0];
            lvl <= lvl + 2'd1;
          end else if (is_unmap) begin
            ok     <= 1'b0;
            status <= ST_NOT_PRES;
          end else if (full) begin
            ok     <= 1'b0;
            status <= ST_NO_SPACE;
          end else begin
            tbl     <= alloc[TW-1:0];
            alloc   <= alloc + CW'(1);
            clr_cnt <= '0;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == '1) lvl <= lvl + 2'd1;
        end
        S_NEXT: begin
          if (!is_unmap) pages <= pages + PAGES_W'(1);
          inval_pg <= vpg[35:0];
          vpg      <= vpg + VPN_W'(1);
          ppg      <= ppg + PFN_W'(1);
          lvl      <= 2'd0;
          tbl      <= '0;
        end
        default: ;
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  always_comb begin
    res.success         = ok;
    res.status          = status;
    res.pages_done      = pages;
    res.invalidate_addr = {inval_pg, 12'b0};
    res.tables_used     = LIMIT_W'(alloc);
  end
endmodule
`default_nettype wire

FILE: rtl/core/page_table_map_unmap_engine_core.sv
// A map or unmap request passes SETUP, then READ and CHECK per level, then LEAF and NEXT
// to DONE unless a level fails; each newly allocated table is cleared first. One request
// at a time, none accepted until the result is taken; a range map walks again per page.
// Reset: synchronous; the root table is cleared while request ready is held low.
// Top level: configuration registers, walker, result register.
// Depends on ptm_pkg, ptm_if, ptm_walker.
`timescale 1ns / 1ps
`default_nettype none
module page_table_map_unmap_engine_core import ptm_pkg::*; #(
  parameter int MAX_TABLES = MAX_TABLES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [PA_W-1:0] cfg_data,
  ptm_req_if.sink           req,
  ptm_rsp_if.source         rsp
);
  cfg_t cfg;
  logic idle, res_valid, res_take, start;
  res_t res, out_r;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_pfn <= '0;
      cfg.limit    <= LIMIT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:   cfg.pool_pfn <= cfg_data[51:12];
        CFG_TABLE_LIMIT: cfg.limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign res_take  = res_valid && (!out_valid || rsp.ready);

  ptm_walker #(.MAX_TABLES(MAX_TABLES)) u_walker (
    .clk, .rst, .cfg, .start,
    .cmd(req.cmd), .virt_addr(req.virt_addr), .phys_addr(req.phys_addr),
    .flags(req.flags), .length_bytes(req.length_bytes),
    .idle, .res_valid, .res_take, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign rsp.valid           = out_valid;
  assign rsp.success         = out_r.success;
  assign rsp.status          = out_r.status;
  assign rsp.pages_done      = out_r.pages_done;
  assign rsp.invalidate_addr = out_r.invalidate_addr;
  assign rsp.tables_used     = out_r.tables_used;
endmodule
`default_nettype wire

FILE: rtl/core/ptm_checker.sv
// Port-level checks for the page table engine, bound to the top level.
// Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptm_port_props import ptm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               success,
  input wire logic [1:0]         status,
  input wire logic [PAGES_W-1:0] pages_done,
  input wire logic [LIMIT_W-1:0] tables_used
);
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pages_done) && $stable(status))
    else $error("stalled result changed");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && success |-> status == ST_OK)
    else $error("success with error status");

  a_unmap_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_NOT_PRES |-> pages_done == '0 && tables_used != '0)
    else $error("walk failure reports pages");
endmodule

bind page_table_map_unmap_engine_core ptm_port_props u_ptm_port_props (
  .clk(clk), .rst(rst),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .success(rsp.success), .status(rsp.status),
  .pages_done(rsp.pages_done), .tables_used(rsp.tables_used)
);
`default_nettype wire

FILE: dv/ptm_checker.sv
// Checker for the page table engine: watches config writes and both channels,
// keeps its own copy of the table pool and compares every result in order.
// Depends on ptm_pkg and ptm_if.
`timescale 1ns / 1ps
module ptm_checker import ptm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [PA_W-1:0] cfg_data,
  ptm_req_if              req,
  ptm_rsp_if              rsp,
  output int              fails,
  output int              pending,
  output int              checked
);
  localparam logic [63:0] FRAME_FIELD = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] PA_MASK   = (64'd1 << PA_W) - 64'd1;
  localparam logic [63:0] PAGE      = 64'd4096;
  localparam int          N_ENT     = MAX_TABLES_DEF * 512;

  logic [63:0] pool_mem [N_ENT];
  int unsigned tables_alloc;
  logic [63:0] pool_base;
  logic [4:0]  table_limit;
  res_t        expected_q [$];

  function automatic logic [63:0] table_addr(int unsigned n);
    return (pool_base + 64'(n) * PAGE) & PA_MASK & FRAME_FIELD;
  endfunction

  // present entry pointing at an allocated table; foreign pointers count as absent
  function automatic bit resolve(logic [63:0] e, output int unsigned n);
    logic [63:0] d;
    n = 0;
    if (!e[0]) return 0;
    d = (((e & FRAME_FIELD) - pool_base) & PA_MASK) >> 12;
    if (d >= 64'(tables_alloc)) return 0;
    n = int'(d);
    return 1;
  endfunction

  function automatic int idx(int unsigned t, logic [63:0] va, int sh);
    return int'(t) * 512 + int'((va >> sh) & 64'h1ff);
  endfunction

  // returns 1 when out of table space
  function automatic bit install_page(logic [63:0] va, logic [63:0] pa, logic [63:0] fl);
    int unsigned t, nxt, lim;
    int          sh [3];
    int          slot;
    sh  = '{39, 30, 21};
    t   = 0;
    lim = (table_limit < MAX_TABLES_DEF) ? table_limit : MAX_TABLES_DEF;
    for (int l = 0; l < 3; l++) begin
      slot = idx(t, va, sh[l]);
      if (!resolve(pool_mem[slot], nxt)) begin
        if (tables_alloc >= lim) return 1;
        nxt = tables_alloc;
        tables_alloc++;
        for (int i = 0; i < 512; i++) pool_mem[nxt*512 + i] = '0;
        pool_mem[slot] = table_addr(nxt) | 64'h3;
      end
      t = nxt;
    end
    pool_mem[idx(t, va, 12)] = (pa & FRAME_FIELD) | fl | 64'h1;
    return 0;
  endfunction

  function automatic bit remove_page(logic [63:0] va);
    int unsigned t, nxt;
    int          sh [3];
    sh = '{39, 30, 21};
    t  = 0;
    for (int l = 0; l < 3; l++) begin
      if (!resolve(pool_mem[idx(t, va, sh[l])], nxt)) return 1;
      t = nxt;
    end
    pool_mem[idx(t, va, 12)] = '0;
    return 0;
  endfunction

  function automatic res_t apply_request(cmd_t c, logic [63:0] va, logic [63:0] pa,
                                         logic [63:0] fl, logic [63:0] len);
    res_t        r;
    logic [63:0] v, p, stop, pages, inval;
    r = '0;
    pages = 0;
    inval = 0;
    case (c)
      CMD_MAP: begin
        if (install_page(va, pa, fl)) r.status = ST_NO_SPACE;
        else begin
          r.success = 1'b1;
          pages = 1;
          inval = va & ~(PAGE - 1);
        end
      end
      CMD_UNMAP: begin
        if (remove_page(va)) r.status = ST_NOT_PRES;
        else begin
          r.success = 1'b1;
          inval = va & ~(PAGE - 1);
        end
      end
      CMD_RANGE: begin
        v    = va & ~(PAGE - 1);
        p    = pa & ~(PAGE - 1);
        stop = (va + len + PAGE - 1) & ~(PAGE - 1);
        if (stop > (64'd1 << VA_W)) stop = 64'd1 << VA_W;
        r.success = 1'b1;
        while (v < stop) begin
          if (install_page(v, p, fl)) begin
            r.success = 1'b0;
            r.status  = ST_NO_SPACE;
            break;
          end
          pages++;
          inval = v;
          v += PAGE;
          p = (p + PAGE) & PA_MASK;
        end
      end
      default: ;
    endcase
    r.pages_done      = pages[PAGES_W-1:0];
    r.invalidate_addr = inval[VA_W-1:0];
    r.tables_used     = tables_alloc[LIMIT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e, a;
    if (rst) begin
      for (int i = 0; i < N_ENT; i++) pool_mem[i] = '0;
      tables_alloc = 1;
      pool_base    = '0;
      table_limit  = 5'd16;
      expected_q.delete();
      fails   <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE) pool_base = 64'(cfg_data) & PA_MASK & FRAME_FIELD;
        else table_limit = cfg_data[4:0];
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(cmd_t'(req.cmd), 64'(req.virt_addr),
                                           64'(req.phys_addr), req.flags,
                                           64'(req.length_bytes)));
      if (rsp.valid && rsp.ready) begin
        a = '{rsp.success, rsp.status, rsp.pages_done, rsp.invalidate_addr,
              rsp.tables_used};
        checked <= checked + 1;
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result %p", a);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (a.success !== e.success || a.status !== e.status ||
              a.pages_done !== e.pages_done || a.invalidate_addr !== e.invalidate_addr ||
              a.tables_used !== e.tables_used) begin
            if (fails < 10) $display("mismatch: exp %p act %p", e, a);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

FILE: dv/tb_page_table_map_unmap_engine_core.sv
// Testbench top for the page table engine: clock, reset, config writes and
// directed plus random requests under several idle/stall mixes.
// Depends on ptm_pkg, ptm_if, ptm_checker and the engine RTL.
`timescale 1ns / 1ps
module tb_page_table_map_unmap_engine_core;
  import ptm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [47:0] VA_TOP = 48'hffff_ffff_f000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic            cfg_index = CFG_POOL_BASE;
  logic [PA_W-1:0] cfg_data = '0;
  int              fails, pending, checked;
  int              snd_idle, rcv_stall;
  int              cycles;
  int              n_map, n_unmap, n_range, n_bad;
  logic [47:0]     mapped_q [$];

  ptm_req_if req ();
  ptm_rsp_if rsp ();

  page_table_map_unmap_engine_core u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .req(req.sink), .rsp(rsp.source)
  );

  ptm_checker u_chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .req, .rsp, .fails, .pending, .checked
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_MAP;
    req.virt_addr = '0;
    req.phys_addr = '0;
    req.flags = '0;
    req.length_bytes = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    rsp.ready <= ($urandom_range(0, 99) >= rcv_stall);

  task automatic send(cmd_t c, logic [47:0] va, logic [51:0] pa, logic [63:0] fl,
                      logic [47:0] len);
    while ($urandom_range(0, 99) < snd_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= c;
    req.virt_addr <= va;
    req.phys_addr <= pa;
    req.flags <= fl;
    req.length_bytes <= len;
    do @(posedge clk); while (!req.ready);
    case (c)
      CMD_MAP: begin n_map++; mapped_q.push_back(va); end
      CMD_UNMAP: n_unmap++;
      CMD_RANGE: begin n_range++; mapped_q.push_back(va); end
      default: n_bad++;
    endcase
    if (mapped_q.size() > 64) void'(mapped_q.pop_front());
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic idx, logic [PA_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [51:0] rnd52();
    return 52'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // virtual addresses clustered on a few table paths so walks hit existing tables
  function automatic logic [47:0] pick_va();
    logic [8:0] l4, l3, l2;
    if ($urandom_range(0, 9) == 0) return 48'(rnd52());
    l4 = $urandom_range(0, 1) ? 9'd0 : 9'd511;
    l3 = 9'($urandom_range(0, 2)) | ($urandom_range(0, 3) == 0 ? 9'h1f0 : 9'h0);
    l2 = 9'($urandom_range(0, 3));
    return {l4, l3, l2, 9'($urandom), 12'($urandom)};
  endfunction

  task automatic random_items(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) send(CMD_MAP, pick_va(), rnd52(), rnd64(), 48'($urandom));
      else if (k < 65)
        send(CMD_UNMAP, (mapped_q.size() > 0 && $urandom_range(0, 3) != 0) ?
             mapped_q[$urandom_range(0, mapped_q.size() - 1)] : pick_va(),
             rnd52(), rnd64(), 48'($urandom));
      else if (k < 90) send(CMD_RANGE, pick_va(), rnd52(), rnd64(), 48'($urandom_range(0, 40000)));
      else if (k < 95)
        send(CMD_RANGE, VA_TOP - 48'($urandom_range(0, 3) * 4096) + 48'($urandom_range(0, 4095)),
             rnd52(), rnd64(), 48'(rnd52()));
      else send(CMD_NONE, 48'(rnd52()), rnd52(), rnd64(), 48'(rnd52()));
    end
  endtask

  initial begin
    snd_idle = 0;
    rcv_stall = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no allocation allowed
    write_reg(CFG_TABLE_LIMIT, 52'd1);
    send(CMD_MAP, 48'h0, '1, '1, '0);
    send(CMD_UNMAP, 48'h0, '0, '0, '0);
    send(CMD_NONE, '1, '1, '1, '1);
    send(CMD_RANGE, 48'h1234, '0, '0, 48'h0);
    send(CMD_RANGE, 48'h1234, '0, '0, 48'h1);
    write_reg(CFG_TABLE_LIMIT, 52'd0);
    send(CMD_MAP, VA_TOP, '0, '0, '0);

    write_reg(CFG_TABLE_LIMIT, 52'd16);
    send(CMD_MAP, 48'h0, '1, '1, '0);
    send(CMD_MAP, '1, '0, '0, '1);
    send(CMD_UNMAP, '1, '0, '0, '0);
    send(CMD_UNMAP, '1, '0, '0, '0);
    send(CMD_UNMAP, 48'h0000_0040_0000, '0, '0, '0);
    send(CMD_RANGE, VA_TOP + 48'h10, 52'hf_ffff_ffff_f123, 64'h8000_0000_0000_0000, '1);
    send(CMD_RANGE, 48'h1f_e800, 52'h5000, 64'h6, 48'h3000);
    send(CMD_RANGE, 48'h7ff, 52'h0, 64'h0, 48'h1802);
    send(CMD_UNMAP, 48'h20_0000, '0, '0, '0);

    // unaligned base: existing pointers become foreign
    write_reg(CFG_POOL_BASE, 52'h1_2345_6789_abcd);
    send(CMD_UNMAP, '1, '0, '0, '0);
    send(CMD_MAP, 48'h0, 52'h1000, 64'h4, '0);
    send(CMD_UNMAP, 48'h0, '0, '0, '0);
    write_reg(CFG_POOL_BASE, 52'h0);
    send(CMD_MAP, 48'h0, 52'h2000, 64'h2, '0);

    write_reg(CFG_TABLE_LIMIT, 52'd8);
    random_items(375);

    snd_idle = 73;
    write_reg(CFG_TABLE_LIMIT, 52'd12);
    random_items(375);
    drain(); // sender holds until the block has answered everything

    snd_idle = 0;
    rcv_stall = 73;
    write_reg(CFG_TABLE_LIMIT, 52'd31);
    random_items(375);

    snd_idle = 27;
    rcv_stall = 27;
    write_reg(CFG_POOL_BASE, 52'hf_ffff_ffff_f000);
    write_reg(CFG_TABLE_LIMIT, 52'd16);
    random_items(375);

    drain();
    repeat (2000) @(posedge clk);
    $display("covered %0d map, %0d unmap, %0d range, %0d unknown requests",
             n_map, n_unmap, n_range, n_bad);
    $display("%0d results compared over four idle/stall mixes, %0d mismatches",
             checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
